>>> design/psched_pkg.sv
// Shared types and constants for the priority scheduler with resources.
`default_nettype none
package psched_pkg;
	localparam int NUM_TASKS  = 16;
	localparam int NUM_RES    = 64;
	localparam int NUM_LEVELS = 3;
	localparam int TASK_W     = 4;
	localparam int RES_W      = 6;
	localparam int LVL_W      = 2;
	localparam int AMT_W      = 8;
	localparam int CNT_W      = 5;
	localparam int ACT_W      = 2;
	localparam int EV_W       = 2;
	localparam int HELD_AW    = TASK_W + RES_W;
	localparam int HELD_DEPTH = NUM_TASKS * NUM_RES;
	localparam int RQ_AW      = LVL_W + TASK_W;
	localparam int RQ_DEPTH   = NUM_LEVELS * NUM_TASKS;

	localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;
	localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd3;

	localparam logic [EV_W-1:0] EV_OK      = 2'd0;
	localparam logic [EV_W-1:0] EV_BLOCKED = 2'd1;
	localparam logic [EV_W-1:0] EV_NO_RUN  = 2'd2;
	localparam logic [EV_W-1:0] EV_FULL    = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_REQ,
		S_DEL,
		S_DEL_END,
		S_RESCH,
		S_UB_RD,
		S_UB_CHK,
		S_DISP,
		S_DISP_WT,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

>>> design/psched_if.sv
// Valid/ready channel interfaces for scheduler commands and status.
`default_nettype none
interface psched_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [psched_pkg::ACT_W-1:0]  action;
	logic [psched_pkg::TASK_W-1:0] task_id;
	logic [psched_pkg::LVL_W-1:0]  task_priority;
	logic [psched_pkg::RES_W-1:0]  resource_index;
	logic [psched_pkg::AMT_W-1:0]  amount;
	modport source (output valid, action, task_id, task_priority, resource_index, amount,
		input ready);
	modport sink (input valid, action, task_id, task_priority, resource_index, amount,
		output ready);
endinterface

interface psched_sts_if;
	logic                          valid;
	logic                          ready;
	logic                          running_valid;
	logic [psched_pkg::TASK_W-1:0] running_task;
	logic [psched_pkg::EV_W-1:0]   event_code;
	modport source (output valid, running_valid, running_task, event_code, input ready);
	modport sink (input valid, running_valid, running_task, event_code, output ready);
endinterface
`default_nettype wire

>>> design/priority_scheduler_with_resources_top.sv
// Top level of the priority scheduler with resources.
// One command is taken at a time and gives one status transfer. A block or a reschedule
// with nothing ready walks the blocked list one blocked task at a time (up to 16); delete
// walks the 64 held-unit entries of the running task through the held-unit memory, then
// reschedules. Ready queues, held units and available units live in synchronous memories
// with registered reads. After reset a clearing pass fills the held-unit memory with zero
// and the available-unit memory with INIT_AVAIL; no command is taken meanwhile. The next
// command is taken while the last status still waits.
`default_nettype none
module priority_scheduler_with_resources_top #(
	parameter int INIT_AVAIL = 15
) (
	input  wire            clk,
	input  wire            arst_n,
	psched_cmd_if.sink     cmd,
	psched_sts_if.source   status
);
	import psched_pkg::*;

	localparam logic [HELD_AW-1:0] CLR_LAST = HELD_AW'(HELD_DEPTH - 1);
	localparam logic [RES_W-1:0]   RES_LAST = RES_W'(NUM_RES - 1);
	localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(NUM_TASKS);
	localparam logic [AMT_W-1:0]   INIT_V   = AMT_W'(INIT_AVAIL);

	state_t state_q, state_d;

	logic [HELD_AW-1:0] clr_q;
	logic [ACT_W-1:0]   act_q;
	logic [TASK_W-1:0]  id_q;
	logic [LVL_W-1:0]   prio_q;
	logic [RES_W-1:0]   res_q;
	logic [AMT_W-1:0]   amt_q;
	logic [EV_W-1:0]    ev_q;
	logic               cur_v_q;
	logic [TASK_W-1:0]  cur_id_q;

	logic [TASK_W-1:0] rq_head_q [NUM_LEVELS];
	logic [TASK_W-1:0] rq_tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]  rq_cnt_q [NUM_LEVELS];
	logic [TASK_W-1:0] blk_q [NUM_TASKS];
	logic [CNT_W-1:0]  blk_cnt_q;
	logic [CNT_W-1:0]  ub_i_q;
	logic [RES_W-1:0]  pend_res_q [NUM_TASKS];
	logic [AMT_W-1:0]  pend_amt_q [NUM_TASKS];
	logic [LVL_W-1:0]  level_q [NUM_TASKS];

	logic [RES_W-1:0] del_r_q;
	logic [RES_W-1:0] del_w_q;
	logic             del_wv_q;

	logic             out_v_q;
	logic             out_run_q;
	logic [TASK_W-1:0] out_task_q;
	logic [EV_W-1:0]  out_ev_q;

	logic [TASK_W-1:0] rq_mem [RQ_DEPTH];
	logic [AMT_W-1:0]  av_mem [NUM_RES];
	logic [AMT_W-1:0]  hd_mem [HELD_DEPTH];
	logic [TASK_W-1:0] rq_rd;
	logic [AMT_W-1:0]  av_rd;
	logic [AMT_W-1:0]  hd_rd;

	logic              push_en;
	logic [LVL_W-1:0]  push_lvl;
	logic [TASK_W-1:0] push_id;
	logic              pop_en;
	logic [RQ_AW-1:0]  rq_raddr;
	logic              av_we;
	logic [RES_W-1:0]  av_waddr;
	logic [AMT_W-1:0]  av_wdata;
	logic [RES_W-1:0]  av_raddr;
	logic              hd_we;
	logic [HELD_AW-1:0] hd_waddr;
	logic [AMT_W-1:0]  hd_wdata;
	logic [HELD_AW-1:0] hd_raddr;

	logic              any_ready;
	logic [LVL_W-1:0]  first_lvl;
	logic [LVL_W-1:0]  lvl_sat;
	logic [LVL_W-1:0]  cur_lvl;
	logic [TASK_W-1:0] ub_t;
	logic [RES_W-1:0]  ub_res;
	logic [AMT_W-1:0]  ub_amt;
	logic [LVL_W-1:0]  ub_lvl;
	logic              ub_fit;
	logic              req_fit;
	logic              blk_full;
	logic              ub_end;
	logic              out_free;

	function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
		input logic [AMT_W-1:0] b);
		logic [AMT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AMT_W] ? {AMT_W{1'b1}} : s[AMT_W-1:0];
	endfunction

	always_comb begin
		any_ready = 1'b0;
		first_lvl = '0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (rq_cnt_q[l] != '0) begin
				any_ready = 1'b1;
				first_lvl = LVL_W'(l);
			end
		end
	end

	assign lvl_sat  = (prio_q >= LVL_W'(NUM_LEVELS)) ? LVL_W'(NUM_LEVELS - 1) : prio_q;
	assign cur_lvl  = level_q[cur_id_q];
	assign ub_t     = blk_q[ub_i_q[TASK_W-1:0]];
	assign ub_res   = pend_res_q[ub_t];
	assign ub_amt   = pend_amt_q[ub_t];
	assign ub_lvl   = level_q[ub_t];
	assign ub_fit   = (av_rd >= ub_amt) && (rq_cnt_q[ub_lvl] != CNT_FULL);
	assign req_fit  = av_rd >= amt_q;
	assign blk_full = blk_cnt_q == CNT_FULL;
	assign ub_end   = ub_i_q >= blk_cnt_q;
	assign out_free = !out_v_q || status.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:   if (clr_q == CLR_LAST) state_d = S_IDLE;
			S_IDLE:    if (cmd.valid) state_d = S_EXEC;
			S_EXEC: begin
				if (act_q == ACT_CREATE) begin
					state_d = (rq_cnt_q[lvl_sat] == CNT_FULL) ? S_DONE : S_DISP;
				end else if (!cur_v_q) begin
					state_d = S_DONE;
				end else begin
					unique case (act_q)
						ACT_REQUEST: state_d = S_REQ;
						ACT_TIMEOUT: state_d = (rq_cnt_q[cur_lvl] == CNT_FULL) ? S_DONE : S_RESCH;
						default:     state_d = S_DEL;
					endcase
				end
			end
			S_REQ:     state_d = (req_fit || blk_full) ? S_DONE : S_UB_RD;
			S_DEL:     if (del_r_q == RES_LAST) state_d = S_DEL_END;
			S_DEL_END: state_d = S_RESCH;
			S_RESCH:   state_d = any_ready ? S_DISP : S_UB_RD;
			S_UB_RD:   state_d = ub_end ? S_DISP : S_UB_CHK;
			S_UB_CHK:  state_d = ub_fit ? S_DISP : S_UB_RD;
			S_DISP:    state_d = (!cur_v_q && any_ready) ? S_DISP_WT : S_DONE;
			S_DISP_WT: state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		push_en  = 1'b0;
		push_lvl = '0;
		push_id  = '0;
		pop_en   = 1'b0;
		rq_raddr = '0;
		av_we    = 1'b0;
		av_waddr = '0;
		av_wdata = '0;
		av_raddr = '0;
		hd_we    = 1'b0;
		hd_waddr = '0;
		hd_wdata = '0;
		hd_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				av_we    = 1'b1;
				av_waddr = clr_q[RES_W-1:0];
				av_wdata = INIT_V;
				hd_we    = 1'b1;
				hd_waddr = clr_q;
			end
			S_EXEC: begin
				if (act_q == ACT_CREATE) begin
					push_en  = rq_cnt_q[lvl_sat] != CNT_FULL;
					push_lvl = lvl_sat;
					push_id  = id_q;
				end else if (cur_v_q && act_q == ACT_TIMEOUT) begin
					push_en  = rq_cnt_q[cur_lvl] != CNT_FULL;
					push_lvl = cur_lvl;
					push_id  = cur_id_q;
				end
				av_raddr = res_q;
				hd_raddr = {cur_id_q, res_q};
			end
			S_REQ: begin
				if (req_fit) begin
					av_we    = 1'b1;
					av_waddr = res_q;
					av_wdata = av_rd - amt_q;
					hd_we    = 1'b1;
					hd_waddr = {cur_id_q, res_q};
					hd_wdata = sat_add(hd_rd, amt_q);
				end
			end
			S_DEL, S_DEL_END: begin
				av_raddr = del_r_q;
				hd_raddr = {cur_id_q, del_r_q};
				av_we    = del_wv_q;
				av_waddr = del_w_q;
				av_wdata = sat_add(av_rd, hd_rd);
				hd_we    = del_wv_q;
				hd_waddr = {cur_id_q, del_w_q};
			end
			S_UB_RD: begin
				av_raddr = ub_res;
				hd_raddr = {ub_t, ub_res};
			end
			S_UB_CHK: begin
				if (ub_fit) begin
					av_we    = 1'b1;
					av_waddr = ub_res;
					av_wdata = av_rd - ub_amt;
					hd_we    = 1'b1;
					hd_waddr = {ub_t, ub_res};
					hd_wdata = sat_add(hd_rd, ub_amt);
					push_en  = 1'b1;
					push_lvl = ub_lvl;
					push_id  = ub_t;
				end
			end
			S_DISP: begin
				pop_en   = !cur_v_q && any_ready;
				rq_raddr = {first_lvl, rq_head_q[first_lvl]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_en) rq_mem[{push_lvl, rq_tail_q[push_lvl]}] <= push_id;
		rq_rd <= rq_mem[rq_raddr];
		if (av_we) av_mem[av_waddr] <= av_wdata;
		av_rd <= av_mem[av_raddr];
		if (hd_we) hd_mem[hd_waddr] <= hd_wdata;
		hd_rd <= hd_mem[hd_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			act_q  <= cmd.action;
			id_q   <= cmd.task_id;
			prio_q <= cmd.task_priority;
			res_q  <= cmd.resource_index;
			amt_q  <= cmd.amount;
		end
		if (state_q == S_EXEC && act_q == ACT_CREATE && rq_cnt_q[lvl_sat] != CNT_FULL) begin
			level_q[id_q] <= lvl_sat;
		end
		if (state_q == S_REQ && !req_fit && !blk_full) begin
			pend_res_q[cur_id_q] <= res_q;
			pend_amt_q[cur_id_q] <= amt_q;
		end
		if (state_q == S_DONE && out_free) begin
			out_run_q  <= cur_v_q;
			out_task_q <= cur_v_q ? cur_id_q : '0;
			out_ev_q   <= ev_q;
		end
		del_w_q <= del_r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			ev_q      <= EV_OK;
			cur_v_q   <= 1'b0;
			cur_id_q  <= '0;
			blk_cnt_q <= '0;
			ub_i_q    <= '0;
			del_r_q   <= '0;
			del_wv_q  <= 1'b0;
			out_v_q   <= 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				rq_head_q[l] <= '0;
				rq_tail_q[l] <= '0;
				rq_cnt_q[l]  <= '0;
			end
			for (int k = 0; k < NUM_TASKS; k++) blk_q[k] <= '0;
		end else begin
			state_q <= state_d;
			out_v_q <= (state_q == S_DONE && out_free) || (out_v_q && !status.ready);
			if (push_en) begin
				rq_tail_q[push_lvl] <= rq_tail_q[push_lvl] + 1'b1;
				rq_cnt_q[push_lvl]  <= rq_cnt_q[push_lvl] + 1'b1;
			end
			if (pop_en) begin
				rq_head_q[first_lvl] <= rq_head_q[first_lvl] + 1'b1;
				rq_cnt_q[first_lvl]  <= rq_cnt_q[first_lvl] - 1'b1;
			end
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_EXEC: begin
					ub_i_q   <= '0;
					del_r_q  <= '0;
					del_wv_q <= 1'b0;
					if (act_q == ACT_CREATE) begin
						ev_q <= (rq_cnt_q[lvl_sat] == CNT_FULL) ? EV_FULL : EV_OK;
					end else if (!cur_v_q) begin
						ev_q <= EV_NO_RUN;
					end else if (act_q == ACT_TIMEOUT) begin
						if (rq_cnt_q[cur_lvl] == CNT_FULL) begin
							ev_q <= EV_FULL;
						end else begin
							ev_q    <= EV_OK;
							cur_v_q <= 1'b0;
						end
					end else begin
						ev_q <= EV_OK;
					end
				end
				S_REQ: begin
					if (!req_fit) begin
						if (blk_full) begin
							ev_q <= EV_FULL;
						end else begin
							blk_q[blk_cnt_q[TASK_W-1:0]] <= cur_id_q;
							blk_cnt_q <= blk_cnt_q + 1'b1;
							cur_v_q   <= 1'b0;
							ev_q      <= EV_BLOCKED;
						end
					end
				end
				S_DEL: begin
					del_r_q  <= del_r_q + 1'b1;
					del_wv_q <= 1'b1;
				end
				S_DEL_END: begin
					del_wv_q <= 1'b0;
					cur_v_q  <= 1'b0;
				end
				S_RESCH: ub_i_q <= '0;
				S_UB_CHK: begin
					if (ub_fit) begin
						for (int k = 0; k < NUM_TASKS - 1; k++) begin
							if (CNT_W'(k) >= ub_i_q) blk_q[k] <= blk_q[k + 1];
						end
						blk_cnt_q <= blk_cnt_q - 1'b1;
					end else begin
						ub_i_q <= ub_i_q + 1'b1;
					end
				end
				S_DISP_WT: begin
					cur_v_q  <= 1'b1;
					cur_id_q <= rq_rd;
				end
				default: begin
				end
			endcase
		end
	end

	assign cmd.ready            = state_q == S_IDLE;
	assign status.valid         = out_v_q;
	assign status.running_valid = out_run_q;
	assign status.running_task  = out_task_q;
	assign status.event_code    = out_ev_q;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> rq_cnt_q[push_lvl] != CNT_FULL)
		else $error("push into full ready queue");
	a_blk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blk_cnt_q <= CNT_FULL)
		else $error("blocked count overflow");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |=> ##1 cur_v_q)
		else $error("dispatch did not start a task");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_v_q) |-> $past(status.ready))
		else $error("status dropped without transfer");
`endif
endmodule
`default_nettype wire
